### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the pointing block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/qop_pkg.sv
// Package for the quaternion offset pointing block: widths, constants,
// register codes and the rounding and saturation helpers. No dependencies.
package qop_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DW        = 16;
    localparam int ONE_I     = 1 << FRAC_BITS;
    localparam logic signed [DW-1:0] ONE = DW'(ONE_I);

    // wide signed accumulator for sums of products
    localparam int RW = 36;
    localparam logic signed [RW-1:0] ONE_W     = RW'(ONE_I);
    localparam logic signed [RW-1:0] NEG_ONE_W = -RW'(ONE_I);
    localparam logic [RW-1:0]        HALF      = RW'(1) << (FRAC_BITS - 1);

    // direction unit (sine and cosine of atan2)
    localparam int AB_W         = 34;
    localparam int MAG_W        = 31;
    localparam int SQ_W         = 64;
    localparam int SQ_ITERS     = 32;
    localparam int SQ_PER_STAGE = 2;
    localparam int SQ_STAGES    = SQ_ITERS / SQ_PER_STAGE;
    localparam int Q_W          = FRAC_BITS + 1;
    localparam int DIV_W        = MAG_W + FRAC_BITS + 3;
    localparam int DIR_LAT      = 3 + SQ_STAGES + 1 + Q_W + 1;

    // cosine of pitch root
    localparam int CP_W     = 2 * FRAC_BITS + 2;
    localparam int CP_ITERS = FRAC_BITS + 1;
    localparam int CP_LAT   = 2 + CP_ITERS + 1;
    localparam int CP_PAD   = DIR_LAT - CP_LAT;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_OFFSET_W = 3'd0,
        REG_OFFSET_X = 3'd1,
        REG_OFFSET_Y = 3'd2,
        REG_OFFSET_Z = 3'd3
    } cfg_reg_t;

    // scale down by 2^FRAC_BITS, nearest, ties away from zero
    function automatic logic signed [RW-1:0] rnd_shift(input logic signed [RW-1:0] v);
        logic [RW-1:0] m;
        m = v[RW-1] ? $unsigned(-v) : $unsigned(v);
        m = (m + HALF) >> FRAC_BITS;
        return v[RW-1] ? -$signed(m) : $signed(m);
    endfunction

    // clamp to [-ONE, ONE]
    function automatic logic signed [DW-1:0] sat_out(input logic signed [RW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > ONE_W)
            r = ONE;
        else if (v < NEG_ONE_W)
            r = -ONE;
        else
            r = v[DW-1:0];
        return r;
    endfunction

endpackage

### hdl/qop_in_if.sv
// Input channel of the pointing block: one orientation quaternion a beat.
// Depends on qop_pkg.
interface qop_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [qop_pkg::DW-1:0]       in_quat_w;
    logic signed [qop_pkg::DW-1:0]       in_quat_x;
    logic signed [qop_pkg::DW-1:0]       in_quat_y;
    logic signed [qop_pkg::DW-1:0]       in_quat_z;

    modport source (output valid, in_quat_w, in_quat_x, in_quat_y, in_quat_z,
                    input ready);
    modport sink   (input valid, in_quat_w, in_quat_x, in_quat_y, in_quat_z,
                    output ready);
endinterface

### hdl/qop_out_if.sv
// Result channel of the pointing block: position, roll sine and rotated
// quaternion a beat. Depends on qop_pkg.
interface qop_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [qop_pkg::DW-1:0]       pos_x;
    logic signed [qop_pkg::DW-1:0]       pos_y;
    logic signed [qop_pkg::DW-1:0]       roll_sine;
    logic signed [qop_pkg::DW-1:0]       rot_w;
    logic signed [qop_pkg::DW-1:0]       rot_x;
    logic signed [qop_pkg::DW-1:0]       rot_y;
    logic signed [qop_pkg::DW-1:0]       rot_z;

    modport source (output valid, pos_x, pos_y, roll_sine, rot_w, rot_x, rot_y, rot_z,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, roll_sine, rot_w, rot_x, rot_y, rot_z,
                    output ready);
endinterface

### hdl/qop_dir.sv
// Pipelined sine and cosine of atan2(a, b): normalise, square, root by
// bit pairs, then restoring division. Depends on qop_pkg.
module qop_dir (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [qop_pkg::AB_W-1:0] a,
    input  logic signed [qop_pkg::AB_W-1:0] b,
    output logic signed [qop_pkg::DW-1:0]   sine,
    output logic signed [qop_pkg::DW-1:0]   cosine
);
    import qop_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0] ma;
        logic [MAG_W-1:0] mb;
        logic             sa;
        logic             sb;
        logic             zero;
    } dir_meta_t;

    typedef struct packed {
        dir_meta_t       m;
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } sq_t;

    typedef struct packed {
        logic             sa;
        logic             sb;
        logic             zero;
        logic [DIV_W-1:0] rs;
        logic [DIV_W-1:0] rc;
        logic [DIV_W-1:0] d;
        logic [Q_W-1:0]   qs;
        logic [Q_W-1:0]   qc;
    } dv_t;

    // one iteration of the bit-pair root, iteration n from the top
    function automatic sq_t sqrt_step(input sq_t s, input int n);
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] t;
        bitv = SQ_W'(1) << (SQ_W - 2 - 2 * n);
        t    = s.r + bitv;
        if (s.v >= t)
        begin
            s.v = s.v - t;
            s.r = (s.r >> 1) + bitv;
        end
        else
        begin
            s.r = s.r >> 1;
        end
        return s;
    endfunction

    // one restoring division step on both quotients, quotient bit qb
    function automatic dv_t div_step(input dv_t s, input int qb);
        logic [DIV_W-1:0] trial;
        trial = s.d << qb;
        if (s.rs >= trial)
        begin
            s.rs     = s.rs - trial;
            s.qs[qb] = 1'b1;
        end
        if (s.rc >= trial)
        begin
            s.rc     = s.rc - trial;
            s.qc[qb] = 1'b1;
        end
        return s;
    endfunction

    logic [AB_W-1:0]     abs_a;
    logic [AB_W-1:0]     abs_b;
    logic [MAG_W-1:0]    na;
    logic [MAG_W-1:0]    nb;
    dir_meta_t           meta1_reg;
    dir_meta_t           meta2_reg;
    logic [2*MAG_W-1:0]  sqa_reg;
    logic [2*MAG_W-1:0]  sqb_reg;
    sq_t                 sq_reg [0:SQ_STAGES];
    dv_t                 dv_reg [0:Q_W];
    logic signed [DW-1:0] sine_reg;
    logic signed [DW-1:0] cosine_reg;

    // magnitudes, halved until both sit below 2^31
    always_comb
    begin
        abs_a = a[AB_W-1] ? $unsigned(-a) : $unsigned(a);
        abs_b = b[AB_W-1] ? $unsigned(-b) : $unsigned(b);
        if (abs_a[MAG_W+1] || abs_b[MAG_W+1])
        begin
            na = abs_a[MAG_W+1:2];
            nb = abs_b[MAG_W+1:2];
        end
        else if (abs_a[MAG_W] || abs_b[MAG_W])
        begin
            na = abs_a[MAG_W:1];
            nb = abs_b[MAG_W:1];
        end
        else
        begin
            na = abs_a[MAG_W-1:0];
            nb = abs_b[MAG_W-1:0];
        end
    end

    // normalise, square, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta1_reg <= '{ma: na, mb: nb, sa: a[AB_W-1], sb: b[AB_W-1],
                           zero: (a == '0) && (b == '0)};
            meta2_reg <= meta1_reg;
            sqa_reg   <= meta1_reg.ma * meta1_reg.ma;
            sqb_reg   <= meta1_reg.mb * meta1_reg.mb;
            sq_reg[0] <= '{m: meta2_reg, v: SQ_W'(sqa_reg) + SQ_W'(sqb_reg), r: '0};
        end
    end

    // root stages, two iterations each
    for (genvar j = 0; j < SQ_STAGES; j++)
    begin : g_sqrt
        sq_t sq_next;
        always_comb
        begin
            sq_next = sq_reg[j];
            for (int i = 0; i < SQ_PER_STAGE; i++)
                sq_next = sqrt_step(sq_next, SQ_PER_STAGE * j + i);
        end
        always_ff @(posedge clk)
        begin
            if (en)
                sq_reg[j+1] <= sq_next;
        end
    end

    // numerators ma*2^(F+1) + r over divisor 2r
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0].sa   <= sq_reg[SQ_STAGES].m.sa;
            dv_reg[0].sb   <= sq_reg[SQ_STAGES].m.sb;
            dv_reg[0].zero <= sq_reg[SQ_STAGES].m.zero;
            dv_reg[0].rs   <= (DIV_W'(sq_reg[SQ_STAGES].m.ma) << (FRAC_BITS + 1))
                              + sq_reg[SQ_STAGES].r[DIV_W-1:0];
            dv_reg[0].rc   <= (DIV_W'(sq_reg[SQ_STAGES].m.mb) << (FRAC_BITS + 1))
                              + sq_reg[SQ_STAGES].r[DIV_W-1:0];
            dv_reg[0].d    <= sq_reg[SQ_STAGES].r[DIV_W-1:0] << 1;
            dv_reg[0].qs   <= '0;
            dv_reg[0].qc   <= '0;
        end
    end

    // division stages, one quotient bit each
    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[k+1] <= div_step(dv_reg[k], Q_W - 1 - k);
        end
    end

    // sign, and the both-zero case
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dv_reg[Q_W].zero)
            begin
                sine_reg   <= '0;
                cosine_reg <= ONE;
            end
            else
            begin
                sine_reg   <= dv_reg[Q_W].sa ? -$signed(DW'(dv_reg[Q_W].qs))
                                             : $signed(DW'(dv_reg[Q_W].qs));
                cosine_reg <= dv_reg[Q_W].sb ? -$signed(DW'(dv_reg[Q_W].qc))
                                             : $signed(DW'(dv_reg[Q_W].qc));
            end
        end
    end

    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

### hdl/quaternion_offset_pointing.sv
// Top level of the quaternion offset pointing block.
// Depends on qop_pkg, qop_in_if, qop_out_if, qop_dir and assert_macros.svh.

// Each beat on sample carries one Q1.14 orientation quaternion; it is
// multiplied by the offset quaternion (offset on the left), and the block
// returns the rotated quaternion, sin(roll) and a two-axis pointing position
// rotated by the offset's own roll. The datapath is a 44-stage pipeline that
// takes one beat every cycle while result is not stalled; most of its depth is in the
// root-and-divide direction units (36 stages). All stages move together: a
// stall on result holds the whole pipeline, and sample.ready follows it in
// the same cycle. Offset registers take effect for beats accepted after the
// write; write them while no beat is in flight.
module quaternion_offset_pointing (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [qop_pkg::DW-1:0]        cfg_data,
    qop_in_if.sink                        sample,
    qop_out_if.source                     result
);
    import qop_pkg::*;
    `include "assert_macros.svh"

    localparam int LAT = 4 + DIR_LAT + 4;

    typedef struct packed {
        logic signed [DW-1:0] sp;
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } side_t;

    // one iteration of the cosine-of-pitch root
    function automatic logic [2*CP_W-1:0] cp_step(input logic [CP_W-1:0] v,
                                                 input logic [CP_W-1:0] r,
                                                 input int k);
        logic [CP_W-1:0] bitv;
        logic [CP_W-1:0] t;
        bitv = CP_W'(1) << (2 * FRAC_BITS - 2 * k);
        t    = r + bitv;
        if (v >= t)
        begin
            v = v - t;
            r = (r >> 1) + bitv;
        end
        else
        begin
            r = r >> 1;
        end
        return {v, r};
    endfunction

    localparam logic [CP_W-1:0] ONE_SQ = CP_W'(ONE_I) << FRAC_BITS;

    logic                  adv;
    logic [LAT-1:0]        valid_reg;
    logic signed [DW-1:0]  offset_w_reg, offset_x_reg, offset_y_reg, offset_z_reg;

    logic signed [31:0]    pa_reg [4][4];
    logic signed [DW-1:0]  oa_reg [4];
    logic signed [DW-1:0]  qb_reg [4];
    logic signed [DW-1:0]  ob_reg [4];

    logic signed [31:0]    c_wy_reg, c_xz_reg, c_xy_reg, c_wz_reg, c_yz_reg, c_wx_reg;
    logic signed [31:0]    c_ww_reg, c_xx_reg, c_yy_reg, c_zz_reg;
    logic signed [31:0]    c_oyz_reg, c_owx_reg, c_oww_reg, c_oxx_reg, c_oyy_reg, c_ozz_reg;
    logic signed [DW-1:0]  qc_reg [4];

    logic signed [AB_W-1:0] ay_reg, by_reg, ar_reg, br_reg, ao_reg, bo_reg;
    logic signed [DW-1:0]   d_sp_reg;
    logic signed [DW-1:0]   qd_reg [4];

    logic signed [DW-1:0]  sy, sr, st, ct;
    side_t                 side_reg [0:DIR_LAT-1];

    logic [CP_W-1:0]       sp2_reg;
    logic [CP_W-1:0]       cpv_reg [0:CP_ITERS];
    logic [CP_W-1:0]       cpr_reg [0:CP_ITERS];
    logic [FRAC_BITS:0]    cp_round_reg;
    logic [FRAC_BITS:0]    cp_dly_reg [0:CP_PAD-1];

    logic signed [31:0]    hp_reg;
    logic signed [DW-1:0]  e1_st_reg, e1_ct_reg, e1_sr_reg;
    side_t                 e1_side_reg;
    logic signed [DW-1:0]  h_reg, e2_st_reg, e2_ct_reg, e2_sr_reg;
    side_t                 e2_side_reg;
    logic signed [31:0]    m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [DW-1:0]  e3_sr_reg;
    side_t                 e3_side_reg;
    logic signed [DW-1:0]  px_reg, py_reg, rs_reg;
    side_t                 out_side_reg;

    // offset component by index, for the product stage
    function automatic logic signed [DW-1:0] oa_in(input int i);
        logic signed [DW-1:0] v;
        case (i)
            0:       v = offset_w_reg;
            1:       v = offset_x_reg;
            2:       v = offset_y_reg;
            default: v = offset_z_reg;
        endcase
        return v;
    endfunction

    // whole pipeline advances unless the output beat is held
    assign adv          = !valid_reg[LAT-1] || result.ready;
    assign sample.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[LAT-2:0], sample.valid};
    end

    // offset registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_w_reg <= ONE;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_OFFSET_W: offset_w_reg <= cfg_data;
                REG_OFFSET_X: offset_x_reg <= cfg_data;
                REG_OFFSET_Y: offset_y_reg <= cfg_data;
                REG_OFFSET_Z: offset_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stages A to D: product, rotation, squares, direction arguments
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // A: all sixteen offset-by-sample products
            oa_reg[0] <= offset_w_reg;
            oa_reg[1] <= offset_x_reg;
            oa_reg[2] <= offset_y_reg;
            oa_reg[3] <= offset_z_reg;
            for (int i = 0; i < 4; i++)
            begin
                pa_reg[i][0] <= oa_in(i) * sample.in_quat_w;
                pa_reg[i][1] <= oa_in(i) * sample.in_quat_x;
                pa_reg[i][2] <= oa_in(i) * sample.in_quat_y;
                pa_reg[i][3] <= oa_in(i) * sample.in_quat_z;
            end

            // B: Hamilton product, rounded and clamped
            qb_reg[0] <= sat_out(rnd_shift(RW'(pa_reg[0][0]) - RW'(pa_reg[1][1])
                                         - RW'(pa_reg[2][2]) - RW'(pa_reg[3][3])));
            qb_reg[1] <= sat_out(rnd_shift(RW'(pa_reg[0][1]) + RW'(pa_reg[1][0])
                                         + RW'(pa_reg[2][3]) - RW'(pa_reg[3][2])));
            qb_reg[2] <= sat_out(rnd_shift(RW'(pa_reg[0][2]) - RW'(pa_reg[1][3])
                                         + RW'(pa_reg[2][0]) + RW'(pa_reg[3][1])));
            qb_reg[3] <= sat_out(rnd_shift(RW'(pa_reg[0][3]) + RW'(pa_reg[1][2])
                                         - RW'(pa_reg[2][1]) + RW'(pa_reg[3][0])));
            ob_reg    <= oa_reg;

            // C: pairwise products of rotated and offset quaternions
            c_wy_reg  <= qb_reg[0] * qb_reg[2];
            c_xz_reg  <= qb_reg[1] * qb_reg[3];
            c_xy_reg  <= qb_reg[1] * qb_reg[2];
            c_wz_reg  <= qb_reg[0] * qb_reg[3];
            c_yz_reg  <= qb_reg[2] * qb_reg[3];
            c_wx_reg  <= qb_reg[0] * qb_reg[1];
            c_ww_reg  <= qb_reg[0] * qb_reg[0];
            c_xx_reg  <= qb_reg[1] * qb_reg[1];
            c_yy_reg  <= qb_reg[2] * qb_reg[2];
            c_zz_reg  <= qb_reg[3] * qb_reg[3];
            c_oyz_reg <= ob_reg[2] * ob_reg[3];
            c_owx_reg <= ob_reg[0] * ob_reg[1];
            c_oww_reg <= ob_reg[0] * ob_reg[0];
            c_oxx_reg <= ob_reg[1] * ob_reg[1];
            c_oyy_reg <= ob_reg[2] * ob_reg[2];
            c_ozz_reg <= ob_reg[3] * ob_reg[3];
            qc_reg    <= qb_reg;

            // D: atan2 arguments and sin(pitch)
            ay_reg   <= (AB_W'(c_xy_reg) + AB_W'(c_wz_reg)) <<< 1;
            by_reg   <= AB_W'(c_ww_reg) + AB_W'(c_xx_reg) - AB_W'(c_yy_reg) - AB_W'(c_zz_reg);
            ar_reg   <= (AB_W'(c_yz_reg) + AB_W'(c_wx_reg)) <<< 1;
            br_reg   <= AB_W'(c_ww_reg) - AB_W'(c_xx_reg) - AB_W'(c_yy_reg) + AB_W'(c_zz_reg);
            ao_reg   <= (AB_W'(c_oyz_reg) + AB_W'(c_owx_reg)) <<< 1;
            bo_reg   <= AB_W'(c_oww_reg) - AB_W'(c_oxx_reg) - AB_W'(c_oyy_reg)
                        + AB_W'(c_ozz_reg);
            d_sp_reg <= sat_out(rnd_shift((RW'(c_wy_reg) - RW'(c_xz_reg)) <<< 1));
            qd_reg   <= qc_reg;
        end
    end

    // direction units: yaw, roll of the rotated quaternion, roll of the offset
    qop_dir u_yaw (
        .clk    (clk),
        .en     (adv),
        .a      (ay_reg),
        .b      (by_reg),
        .sine   (sy),
        .cosine ()
    );

    qop_dir u_roll (
        .clk    (clk),
        .en     (adv),
        .a      (ar_reg),
        .b      (br_reg),
        .sine   (sr),
        .cosine ()
    );

    qop_dir u_off (
        .clk    (clk),
        .en     (adv),
        .a      (ao_reg),
        .b      (bo_reg),
        .sine   (st),
        .cosine (ct)
    );

    // side line: sin(pitch) and rotated quaternion wait for the direction units
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= '{sp: d_sp_reg, w: qd_reg[0], x: qd_reg[1],
                             y: qd_reg[2], z: qd_reg[3]};
            for (int i = 1; i < DIR_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // cos(pitch): nearest root of ONE^2 - sin^2, then padding delay
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp2_reg    <= CP_W'(32'(d_sp_reg) * 32'(d_sp_reg));
            cpv_reg[0] <= ONE_SQ - sp2_reg;
            cpr_reg[0] <= '0;
            cp_round_reg <= (cpv_reg[CP_ITERS] > cpr_reg[CP_ITERS])
                            ? cpr_reg[CP_ITERS][FRAC_BITS:0] + 1'b1
                            : cpr_reg[CP_ITERS][FRAC_BITS:0];
            cp_dly_reg[0] <= cp_round_reg;
            for (int i = 1; i < CP_PAD; i++)
                cp_dly_reg[i] <= cp_dly_reg[i-1];
        end
    end

    for (genvar k = 0; k < CP_ITERS; k++)
    begin : g_cp
        always_ff @(posedge clk)
        begin
            if (adv)
                {cpv_reg[k+1], cpr_reg[k+1]} <= cp_step(cpv_reg[k], cpr_reg[k], k);
        end
    end

    // stages E1 to E4: pointing position, rotated by the offset roll
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hp_reg      <= sy * $signed({1'b0, cp_dly_reg[CP_PAD-1]});
            e1_st_reg   <= st;
            e1_ct_reg   <= ct;
            e1_sr_reg   <= sr;
            e1_side_reg <= side_reg[DIR_LAT-1];

            h_reg       <= DW'(rnd_shift(RW'(hp_reg)));
            e2_st_reg   <= e1_st_reg;
            e2_ct_reg   <= e1_ct_reg;
            e2_sr_reg   <= e1_sr_reg;
            e2_side_reg <= e1_side_reg;

            m1_reg      <= e2_st_reg * e2_side_reg.sp;
            m2_reg      <= e2_ct_reg * h_reg;
            m3_reg      <= e2_ct_reg * e2_side_reg.sp;
            m4_reg      <= e2_st_reg * h_reg;
            e3_sr_reg   <= e2_sr_reg;
            e3_side_reg <= e2_side_reg;

            px_reg       <= sat_out(rnd_shift(RW'(m1_reg) - RW'(m2_reg)));
            py_reg       <= sat_out(rnd_shift(RW'(m3_reg) + RW'(m4_reg)));
            rs_reg       <= sat_out(RW'(e3_sr_reg));
            out_side_reg <= e3_side_reg;
        end
    end

    assign result.valid     = valid_reg[LAT-1];
    assign result.pos_x     = px_reg;
    assign result.pos_y     = py_reg;
    assign result.roll_sine = rs_reg;
    assign result.rot_w     = out_side_reg.w;
    assign result.rot_x     = out_side_reg.x;
    assign result.rot_y     = out_side_reg.y;
    assign result.rot_z     = out_side_reg.z;

    // checks
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(valid_reg), "pipeline moved during stall")
    `ASSERT_NEXT(a_accept_enters, clk, rst_n, sample.valid && sample.ready, valid_reg[0], "accepted beat lost at entry")
    `ASSERT_IMPL(a_pos_range, clk, rst_n, result.valid, (result.pos_x <= ONE) && (result.pos_x >= -ONE) && (result.pos_y <= ONE) && (result.pos_y >= -ONE), "position out of range")

endmodule
